/* rtl/sktd_pkg.sv */
// Shared types, constants and request codes of the substitution key table decoder.
package sktd_pkg;

   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int ALPHA = 26;
   localparam int INDEX_BITS = 5;
   localparam int TOTAL_BITS = 21;
   localparam int SCALE_BITS = 14;
   localparam int PCT_BITS = 14;
   localparam int QUOT_BITS = 15;
   localparam int COUNT_OUT_BITS = 16;
   localparam int COUNT_EXT_BITS = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] LETTER_LO = 8'd65;
   localparam logic [7:0] LETTER_HI = 8'd90;
   localparam logic [SCALE_BITS-1:0] SCALE = 14'd10000;
   localparam logic [QUOT_BITS-1:0] SCALE_Q = 15'd10000;
   localparam logic [PCT_BITS-1:0] PCT_MAX = 14'd10000;
   localparam logic [COUNT_OUT_BITS-1:0] COUNT_OUT_MAX = 16'hFFFF;

   localparam logic [1:0] KIND_COUNT = 2'd0;
   localparam logic [1:0] KIND_DECODE = 2'd1;
   localparam logic [1:0] KIND_KEY = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] symbol;
      logic letter;
      logic plain_ok;
      logic [INDEX_BITS-1:0] idx;
      logic [INDEX_BITS-1:0] pidx;
   } item_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic from_key;
      logic [COUNT_OUT_BITS-1:0] letter_count;
      logic [PCT_BITS-1:0] percent_hundredths;
      logic accepted;
   } rsp_type;

endpackage

/* rtl/sktd_front.sv */
// Front end: classifies each request and holds it in a two-entry queue for the back end.
module sktd_front (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  logic [1:0] req_type,
   input  logic [7:0] req_symbol,
   input  logic [7:0] req_plain_letter,
   output logic item_valid,
   output sktd_pkg::item_type item,
   input  logic item_pop
);

   localparam int FILL_BITS = $clog2(sktd_pkg::QUEUE_DEPTH + 1);

   sktd_pkg::item_type slots_ff [sktd_pkg::QUEUE_DEPTH];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [FILL_BITS-1:0] fill_ff, fill_in;
   sktd_pkg::item_type classified;
   logic do_push;
   logic do_pop;

   always_comb begin
      classified.kind = req_type;
      classified.symbol = req_symbol;
      classified.letter = (req_symbol >= sktd_pkg::LETTER_LO) &&
                          (req_symbol <= sktd_pkg::LETTER_HI);
      classified.plain_ok = (req_plain_letter >= sktd_pkg::LETTER_LO) &&
                            (req_plain_letter <= sktd_pkg::LETTER_HI);
      classified.idx = classified.letter ?
                       sktd_pkg::INDEX_BITS'(req_symbol - sktd_pkg::LETTER_LO) : '0;
      classified.pidx = classified.plain_ok ?
                        sktd_pkg::INDEX_BITS'(req_plain_letter - sktd_pkg::LETTER_LO) : '0;
   end

   assign full = (fill_ff == FILL_BITS'(sktd_pkg::QUEUE_DEPTH));
   assign item_valid = (fill_ff != '0);
   assign item = slots_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = item_pop && item_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in = fill_ff + FILL_BITS'(do_push) - FILL_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

/* rtl/sktd_div.sv */
// Restoring divider that turns a scaled count and the total into a clamped percentage.
module sktd_div #(
   parameter int NUM_BITS = sktd_pkg::COUNT_BITS_DEFAULT + sktd_pkg::SCALE_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [NUM_BITS-1:0] numer,
   input  logic [sktd_pkg::TOTAL_BITS-1:0] denom,
   output logic done,
   output logic [sktd_pkg::PCT_BITS-1:0] quot
);

   localparam int SHIFT_BITS = sktd_pkg::TOTAL_BITS + sktd_pkg::QUOT_BITS;
   localparam int W = (NUM_BITS > SHIFT_BITS) ? NUM_BITS : SHIFT_BITS;
   localparam int STEP_BITS = $clog2(sktd_pkg::QUOT_BITS);
   localparam int QB = sktd_pkg::QUOT_BITS;

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [W-1:0] rem_ff, rem_in;
   logic [W-1:0] dsh_ff, dsh_in;
   logic [QB-1:0] q_ff, q_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [sktd_pkg::PCT_BITS-1:0] quot_ff, quot_in;
   logic [W-1:0] numer_w;
   logic [W-1:0] top_w;
   logic fits;

   assign numer_w = W'(numer);
   assign top_w = W'({denom, QB'(0)});
   assign fits = (rem_ff >= dsh_ff);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      q_in = q_ff;
      step_in = step_ff;
      quot_in = quot_ff;
      if (busy_ff) begin
         rem_in = fits ? rem_ff - dsh_ff : rem_ff;
         q_in = {q_ff[QB-2:0], fits};
         dsh_in = dsh_ff >> 1;
         step_in = step_ff - STEP_BITS'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            quot_in = (q_in > sktd_pkg::SCALE_Q) ? sktd_pkg::PCT_MAX
                                                  : q_in[sktd_pkg::PCT_BITS-1:0];
         end
      end else if (start) begin
         if (denom == '0) begin
            quot_in = '0;
            done_in = 1'b1;
         end else if (numer_w >= top_w) begin
            quot_in = sktd_pkg::PCT_MAX;
            done_in = 1'b1;
         end else begin
            rem_in = numer_w;
            dsh_in = W'({denom, (QB-1)'(0)});
            q_in = '0;
            step_in = STEP_BITS'(QB - 1);
            busy_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff <= q_in;
      step_ff <= step_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

/* rtl/sktd_back.sv */
// Back end: applies each request to the letter table and builds its response.
module sktd_back #(
   parameter int COUNT_BITS = sktd_pkg::COUNT_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic item_valid,
   input  sktd_pkg::item_type item,
   output logic item_pop,
   input  logic pop,
   output logic rsp_valid,
   output sktd_pkg::rsp_type rsp
);

   localparam int NUM_BITS = COUNT_BITS + sktd_pkg::SCALE_BITS;
   localparam int TB = sktd_pkg::TOTAL_BITS;
   localparam int IB = sktd_pkg::INDEX_BITS;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL = 2'd1;
   localparam logic [1:0] ST_START = 2'd2;
   localparam logic [1:0] ST_WAIT = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [COUNT_BITS-1:0] counts_ff [sktd_pkg::ALPHA];
   logic [COUNT_BITS-1:0] counts_in [sktd_pkg::ALPHA];
   logic [IB-1:0] keys_ff [sktd_pkg::ALPHA];
   logic [IB-1:0] keys_in [sktd_pkg::ALPHA];
   logic [sktd_pkg::ALPHA-1:0] marks_ff, marks_in;
   logic [TB-1:0] total_ff, total_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [NUM_BITS-1:0] prod_ff, prod_in;
   logic [7:0] oc_ff, oc_in;
   logic fk_ff, fk_in;
   logic acc_ff, acc_in;
   logic out_valid_ff, out_valid_in;
   sktd_pkg::rsp_type out_ff, out_in;
   logic [COUNT_BITS-1:0] cur;
   logic [COUNT_BITS-1:0] cnt_new;
   logic [sktd_pkg::COUNT_EXT_BITS-1:0] cnt_ext;
   logic div_start;
   logic div_done;
   logic [sktd_pkg::PCT_BITS-1:0] div_quot;

   sktd_div #(
      .NUM_BITS(NUM_BITS)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .numer(prod_ff),
      .denom(total_ff),
      .done(div_done),
      .quot(div_quot)
   );

   assign cur = counts_ff[item.idx];
   assign cnt_ext = sktd_pkg::COUNT_EXT_BITS'(cnt_ff);
   assign div_start = (state_ff == ST_START);

   always_comb begin
      state_in = state_ff;
      counts_in = counts_ff;
      keys_in = keys_ff;
      marks_in = marks_ff;
      total_in = total_ff;
      cnt_in = cnt_ff;
      prod_in = prod_ff;
      oc_in = oc_ff;
      fk_in = fk_ff;
      acc_in = acc_ff;
      out_in = out_ff;
      out_valid_in = out_valid_ff && !pop;
      item_pop = 1'b0;
      cnt_new = cur;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid && !out_valid_ff) begin
               item_pop = 1'b1;
               state_in = ST_MUL;
               oc_in = item.symbol;
               fk_in = 1'b0;
               acc_in = 1'b0;
               unique case (item.kind)
                  sktd_pkg::KIND_COUNT: begin
                     if (item.letter && (cur != '1)) begin
                        cnt_new = cur + COUNT_BITS'(1);
                        counts_in[item.idx] = cnt_new;
                        if (total_ff != '1) begin
                           total_in = total_ff + TB'(1);
                        end
                     end
                  end
                  sktd_pkg::KIND_DECODE: begin
                     if (item.letter && marks_ff[item.idx]) begin
                        oc_in = sktd_pkg::LETTER_LO + 8'(keys_ff[item.idx]);
                        fk_in = 1'b1;
                     end
                  end
                  sktd_pkg::KIND_KEY: begin
                     if (item.letter && item.plain_ok) begin
                        acc_in = 1'b1;
                        for (int i = 0; i < sktd_pkg::ALPHA; i++) begin
                           if (IB'(i) == item.idx) begin
                              if (counts_ff[i] != '0) begin
                                 keys_in[i] = item.pidx;
                                 marks_in[i] = 1'b1;
                              end
                           end else if (marks_ff[i] && (keys_ff[i] == item.pidx)) begin
                              keys_in[i] = '0;
                              marks_in[i] = 1'b0;
                           end
                        end
                     end
                  end
                  default: begin
                  end
               endcase
               cnt_in = item.letter ? cnt_new : '0;
            end
         end
         ST_MUL: begin
            prod_in = NUM_BITS'(cnt_ff) * NUM_BITS'(sktd_pkg::SCALE);
            state_in = ST_START;
         end
         ST_START: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_done) begin
               out_in.out_char = oc_ff;
               out_in.from_key = fk_ff;
               out_in.letter_count =
                  (cnt_ext > sktd_pkg::COUNT_EXT_BITS'(sktd_pkg::COUNT_OUT_MAX)) ?
                  sktd_pkg::COUNT_OUT_MAX : cnt_ext[sktd_pkg::COUNT_OUT_BITS-1:0];
               out_in.percent_hundredths = div_quot;
               out_in.accepted = acc_ff;
               out_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
         marks_ff <= '0;
         total_ff <= '0;
         for (int i = 0; i < sktd_pkg::ALPHA; i++) begin
            counts_ff[i] <= '0;
            keys_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
         marks_ff <= marks_in;
         total_ff <= total_in;
         counts_ff <= counts_in;
         keys_ff <= keys_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      prod_ff <= prod_in;
      oc_ff <= oc_in;
      fk_ff <= fk_in;
      acc_ff <= acc_in;
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp = out_ff;

endmodule

/* rtl/substitution_key_table_decoder.sv */
// Top level of the substitution key table decoder.
// An accepted request passes the back-end states ST_MUL, ST_START and ST_WAIT, where
// the 15-step divider iterates unless the percentage clamps or the total is zero.
// The back end handles one request at a time and takes the next only once its response is popped.
// Reset: synchronous, active high; clears all counts, key letters, key marks, the
// total, the request queue and the held response.
module substitution_key_table_decoder #(
   parameter int COUNT_BITS = sktd_pkg::COUNT_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  logic [1:0] req_type,
   input  logic [7:0] req_symbol,
   input  logic [7:0] req_plain_letter,
   output logic empty,
   input  logic pop,
   output logic [7:0] rsp_out_char,
   output logic rsp_from_key,
   output logic [15:0] rsp_letter_count,
   output logic [13:0] rsp_percent_hundredths,
   output logic rsp_accepted
);

   logic item_valid;
   logic item_pop;
   sktd_pkg::item_type item;
   logic rsp_valid;
   sktd_pkg::rsp_type rsp;

   sktd_front u_front (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_type(req_type),
      .req_symbol(req_symbol),
      .req_plain_letter(req_plain_letter),
      .item_valid(item_valid),
      .item(item),
      .item_pop(item_pop)
   );

   sktd_back #(
      .COUNT_BITS(COUNT_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .item_valid(item_valid),
      .item(item),
      .item_pop(item_pop),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp(rsp)
   );

   assign empty = !rsp_valid;
   assign rsp_out_char = rsp.out_char;
   assign rsp_from_key = rsp.from_key;
   assign rsp_letter_count = rsp.letter_count;
   assign rsp_percent_hundredths = rsp.percent_hundredths;
   assign rsp_accepted = rsp.accepted;

endmodule
